// ===== rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the banker's safety check
// Sizes, command and register codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 16;
   localparam int COUNT_WIDTH   = 16;
   localparam int WORK_WIDTH    = COUNT_WIDTH + 4;
   localparam int PROC_W        = $clog2(MAX_PROCESSES);
   localparam int RES_W         = $clog2(MAX_RESOURCES);
   localparam int PCNT_W        = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W        = $clog2(MAX_RESOURCES + 1);
   localparam int CFG_W         = 5;

   // input commands
   localparam logic [1:0] CMD_LOAD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_LOAD_CLAIM = 2'd1;
   localparam logic [1:0] CMD_LOAD_AVAIL = 2'd2;
   localparam logic [1:0] CMD_START      = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_VERDICT  = 2'd0;
   localparam logic [1:0] KIND_ORDER    = 2'd1;
   localparam logic [1:0] KIND_DEADLOCK = 2'd2;

   // register indexes
   localparam logic [1:0] REG_PROC_COUNT = 2'd0;
   localparam logic [1:0] REG_RES_COUNT  = 2'd1;
   localparam logic [1:0] REG_MODE       = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_FETCH,
      ST_INIT_LOAD,
      ST_NEXT,
      ST_ROW_FETCH,
      ST_DECIDE,
      ST_VERDICT,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic shift;
      logic load_work;
      logic commit;
      logic detect;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/bdc_ram.sv =====
// ----------------------------------------------------------------------------
// bdc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bdc_cell.sv =====
// ----------------------------------------------------------------------------
// bdc_cell: one resource column of the check chain
// Holds a work entry and the allocation/claim of the current process row,
// passes the row data on to its neighbor, and reports whether demand fits.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bdc_pkg::cell_ctl_type             ctl,
   input  wire logic [bdc_pkg::COUNT_WIDTH-1:0]   alloc_in,
   input  wire logic [bdc_pkg::COUNT_WIDTH-1:0]   claim_in,
   input  wire logic                              act_in,
   output logic      [bdc_pkg::COUNT_WIDTH-1:0]   alloc_out,
   output logic      [bdc_pkg::COUNT_WIDTH-1:0]   claim_out,
   output logic                                   act_out,
   output logic                                   fit
);

   logic [bdc_pkg::COUNT_WIDTH-1:0] alloc_ff;
   logic [bdc_pkg::COUNT_WIDTH-1:0] claim_ff;
   logic                            act_ff;
   logic [bdc_pkg::WORK_WIDTH-1:0]  work_ff;
   logic [bdc_pkg::WORK_WIDTH-1:0]  work_in;
   logic [bdc_pkg::COUNT_WIDTH-1:0] demand;
   logic [bdc_pkg::WORK_WIDTH:0]    sum;

   // row data shifts one cell per cycle while ctl.shift is set
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         alloc_ff <= alloc_in;
         claim_ff <= claim_in;
         act_ff   <= act_in;
      end
   end

   // need is claim minus allocation, floored at zero; in detect mode it is the claim
   always_comb begin
      if (ctl.detect) begin
         demand = claim_ff;
      end else if (claim_ff > alloc_ff) begin
         demand = claim_ff - alloc_ff;
      end else begin
         demand = '0;
      end
      fit = !act_ff || ({{(bdc_pkg::WORK_WIDTH - bdc_pkg::COUNT_WIDTH){1'b0}}, demand}
                        <= work_ff);
   end

   // work entry: load or saturating add
   always_comb begin
      sum = {1'b0, work_ff}
            + {{(bdc_pkg::WORK_WIDTH + 1 - bdc_pkg::COUNT_WIDTH){1'b0}}, alloc_ff};
      work_in = work_ff;
      if (ctl.load_work) begin
         work_in = act_ff
            ? {{(bdc_pkg::WORK_WIDTH - bdc_pkg::COUNT_WIDTH){1'b0}}, alloc_ff}
            : '0;
      end else if (ctl.commit && act_ff) begin
         work_in = sum[bdc_pkg::WORK_WIDTH] ? '1 : sum[bdc_pkg::WORK_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
      end else begin
         work_ff <= work_in;
      end
   end

   assign alloc_out = alloc_ff;
   assign claim_out = claim_ff;
   assign act_out   = act_ff;

endmodule

`default_nettype wire

// ===== rtl/bankers_safety_and_deadlock_check.sv =====
// ----------------------------------------------------------------------------
// bankers_safety_and_deadlock_check: banker's safety / deadlock detection
// Loads allocation, claim and available stores, then runs the sweep check.
// ----------------------------------------------------------------------------
// Usage:
//  req_* stream: tuser carries the command; load commands write one store
//  entry each. A start command drops req_tready until the
//  whole result run has been handed to the output register.
//  rsp_* stream: a verdict first, then the safe order (safety mode) or each
//  deadlocked process (detection mode); tlast marks the final item of a run.
//  Check sequence: the fetch state streams the available store through the
//  resource cell chain and the load state latches it as the work vector;
//  then per visited process a select state, a fetch state that streams its
//  row through the chain from the RAM read port, and a decide state; at most
//  n sweeps of n processes. Detection mode emission skips finished processes.
//  csr_*: register writes take effect at once; write only while idle.
//  Reset: sync, active high; clears counts to 1, mode to safety, control.
//  Store contents are undefined until loaded. A stalled receiver holds the
//  result in the output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_and_deadlock_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // command
   input  wire logic [23:0] req_tdata,   // process_index, resource_index, amount
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // record_kind
   output logic [7:0]       rsp_tdata,   // process_id, is_safe, zero pad
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   localparam int NP = bdc_pkg::MAX_PROCESSES;
   localparam int NR = bdc_pkg::MAX_RESOURCES;
   localparam int CW = bdc_pkg::COUNT_WIDTH;
   localparam int PW = bdc_pkg::PROC_W;
   localparam int RW = bdc_pkg::RES_W;
   localparam int PC = bdc_pkg::PCNT_W;
   localparam int RC = bdc_pkg::RCNT_W;

   // request fields
   logic [PW-1:0] req_pidx;
   logic [RW-1:0] req_ridx;
   logic [CW-1:0] req_amount;
   logic          req_fire;
   assign req_pidx   = req_tdata[PW-1:0];
   assign req_ridx   = req_tdata[PW+RW-1:PW];
   assign req_amount = req_tdata[PW+RW+CW-1:PW+RW];
   assign req_fire   = req_tvalid && req_tready;

   // configuration
   logic [bdc_pkg::CFG_W-1:0] pcount_ff, rcount_ff;
   logic                      mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= bdc_pkg::CFG_W'(1);
         rcount_ff <= bdc_pkg::CFG_W'(1);
         mode_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            bdc_pkg::REG_PROC_COUNT: pcount_ff <= csr_wdata;
            bdc_pkg::REG_RES_COUNT:  rcount_ff <= csr_wdata;
            bdc_pkg::REG_MODE:       mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped counts
   logic [PC-1:0] n_cnt;
   logic [RC-1:0] m_cnt;
   always_comb begin
      if (pcount_ff == '0) begin
         n_cnt = PC'(1);
      end else if (32'(pcount_ff) > NP) begin
         n_cnt = PC'(NP);
      end else begin
         n_cnt = PC'(pcount_ff);
      end
      if (rcount_ff == '0) begin
         m_cnt = RC'(1);
      end else if (32'(rcount_ff) > NR) begin
         m_cnt = RC'(NR);
      end else begin
         m_cnt = RC'(rcount_ff);
      end
   end

   // sequencer registers
   bdc_pkg::state_type state_ff, state_in;
   logic [RC-1:0]  cnt_ff, cnt_in;
   logic [RW-1:0]  ridx_d_ff;
   logic [PC-1:0]  p_ff, p_in;
   logic [PC-1:0]  len_ff, len_in;
   logic [PC-1:0]  e_ff, e_in;
   logic [PC-1:0]  left_ff, left_in;
   logic           progress_ff, progress_in;
   logic [NP-1:0]  fin_ff, fin_in;
   logic [PW-1:0]  order_ff [NP];
   logic           order_we;

   // output register
   logic           rv_ff, rv_in;
   logic [1:0]     kind_ff, kind_in;
   logic [PW-1:0]  pid_ff, pid_in;
   logic           safe_ff, safe_in;
   logic           last_ff, last_in;
   logic           slot_free;
   assign slot_free = !rv_ff || rsp_tready;

   // stores
   logic [RW-1:0]    rd_ridx;
   logic [CW-1:0]    alloc_rd, claim_rd, avail_rd;
   assign rd_ridx = RW'(NR - 1) - cnt_ff[RW-1:0];

   bdc_ram #(.WIDTH(CW), .DEPTH(NP * NR)) u_alloc (
      .clock   (clock),
      .wr_en   (req_fire && req_tuser == bdc_pkg::CMD_LOAD_ALLOC),
      .wr_addr ({req_pidx, req_ridx}),
      .wr_data (req_amount),
      .rd_addr ({p_ff[PW-1:0], rd_ridx}),
      .rd_data (alloc_rd)
   );

   bdc_ram #(.WIDTH(CW), .DEPTH(NP * NR)) u_claim (
      .clock   (clock),
      .wr_en   (req_fire && req_tuser == bdc_pkg::CMD_LOAD_CLAIM),
      .wr_addr ({req_pidx, req_ridx}),
      .wr_data (req_amount),
      .rd_addr ({p_ff[PW-1:0], rd_ridx}),
      .rd_data (claim_rd)
   );

   bdc_ram #(.WIDTH(CW), .DEPTH(NR)) u_avail (
      .clock   (clock),
      .wr_en   (req_fire && req_tuser == bdc_pkg::CMD_LOAD_AVAIL),
      .wr_addr (req_ridx),
      .wr_data (req_amount),
      .rd_addr (rd_ridx),
      .rd_data (avail_rd)
   );

   // resource cell chain
   bdc_pkg::cell_ctl_type ctl;
   logic [CW-1:0] ch_alloc [NR+1];
   logic [CW-1:0] ch_claim [NR+1];
   logic          ch_act   [NR+1];
   logic [NR-1:0] fit_vec;
   logic          fit_all;

   assign ch_alloc[0] = (state_ff == bdc_pkg::ST_INIT_FETCH) ? avail_rd : alloc_rd;
   assign ch_claim[0] = (state_ff == bdc_pkg::ST_INIT_FETCH) ? '0 : claim_rd;
   assign ch_act[0]   = RC'(ridx_d_ff) < m_cnt;

   for (genvar g = 0; g < NR; g++) begin : g_cell
      bdc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .alloc_in  (ch_alloc[g]),
         .claim_in  (ch_claim[g]),
         .act_in    (ch_act[g]),
         .alloc_out (ch_alloc[g+1]),
         .claim_out (ch_claim[g+1]),
         .act_out   (ch_act[g+1]),
         .fit       (fit_vec[g])
      );
   end
   assign fit_all = &fit_vec;

   logic fetching;
   assign fetching = (state_ff == bdc_pkg::ST_INIT_FETCH)
                  || (state_ff == bdc_pkg::ST_ROW_FETCH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdc_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == bdc_pkg::CMD_START) begin
               state_in = bdc_pkg::ST_INIT_FETCH;
            end
         end
         bdc_pkg::ST_INIT_FETCH: begin
            if (cnt_ff == RC'(NR)) state_in = bdc_pkg::ST_INIT_LOAD;
         end
         bdc_pkg::ST_INIT_LOAD: state_in = bdc_pkg::ST_NEXT;
         bdc_pkg::ST_NEXT: begin
            if (p_ff == n_cnt) begin
               if (!(progress_ff && len_ff < n_cnt)) state_in = bdc_pkg::ST_VERDICT;
            end else if (!fin_ff[p_ff[PW-1:0]]) begin
               state_in = bdc_pkg::ST_ROW_FETCH;
            end
         end
         bdc_pkg::ST_ROW_FETCH: begin
            if (cnt_ff == RC'(NR)) state_in = bdc_pkg::ST_DECIDE;
         end
         bdc_pkg::ST_DECIDE: state_in = bdc_pkg::ST_NEXT;
         bdc_pkg::ST_VERDICT: begin
            if (slot_free) begin
               if ((len_ff == n_cnt) == mode_ff) state_in = bdc_pkg::ST_IDLE;
               else state_in = bdc_pkg::ST_LIST;
            end
         end
         bdc_pkg::ST_LIST: begin
            if (!mode_ff) begin
               if (slot_free && e_ff + PC'(1) == len_ff) state_in = bdc_pkg::ST_IDLE;
            end else if (!fin_ff[e_ff[PW-1:0]] && slot_free && left_ff == PC'(1)) begin
               state_in = bdc_pkg::ST_IDLE;
            end
         end
         default: state_in = bdc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in      = cnt_ff;
      p_in        = p_ff;
      len_in      = len_ff;
      e_in        = e_ff;
      left_in     = left_ff;
      progress_in = progress_ff;
      fin_in      = fin_ff;
      order_we    = 1'b0;
      rv_in       = rv_ff && !rsp_tready;
      kind_in     = kind_ff;
      pid_in      = pid_ff;
      safe_in     = safe_ff;
      last_in     = last_ff;
      ctl.shift     = fetching && cnt_ff != '0;
      ctl.load_work = state_ff == bdc_pkg::ST_INIT_LOAD;
      ctl.commit    = 1'b0;
      ctl.detect    = mode_ff;
      req_tready    = state_ff == bdc_pkg::ST_IDLE;
      if (fetching) cnt_in = cnt_ff + RC'(1);
      case (state_ff)
         bdc_pkg::ST_IDLE: begin
            cnt_in      = '0;
            p_in        = '0;
            len_in      = '0;
            progress_in = 1'b0;
            fin_in      = '0;
         end
         bdc_pkg::ST_NEXT: begin
            cnt_in = '0;
            if (p_ff == n_cnt) begin
               p_in        = '0;
               progress_in = 1'b0;
            end else if (fin_ff[p_ff[PW-1:0]]) begin
               p_in = p_ff + PC'(1);
            end
         end
         bdc_pkg::ST_DECIDE: begin
            p_in = p_ff + PC'(1);
            if (fit_all) begin
               ctl.commit            = 1'b1;
               fin_in[p_ff[PW-1:0]]  = 1'b1;
               order_we              = 1'b1;
               len_in                = len_ff + PC'(1);
               progress_in           = 1'b1;
            end
         end
         bdc_pkg::ST_VERDICT: begin
            e_in    = '0;
            left_in = n_cnt - len_ff;
            if (slot_free) begin
               rv_in   = 1'b1;
               kind_in = bdc_pkg::KIND_VERDICT;
               pid_in  = '0;
               safe_in = len_ff == n_cnt;
               last_in = (len_ff == n_cnt) == mode_ff;
            end
         end
         bdc_pkg::ST_LIST: begin
            if (!mode_ff) begin
               if (slot_free) begin
                  rv_in   = 1'b1;
                  kind_in = bdc_pkg::KIND_ORDER;
                  pid_in  = order_ff[e_ff[PW-1:0]];
                  safe_in = 1'b1;
                  last_in = e_ff + PC'(1) == len_ff;
                  e_in    = e_ff + PC'(1);
               end
            end else if (fin_ff[e_ff[PW-1:0]]) begin
               e_in = e_ff + PC'(1);
            end else if (slot_free) begin
               rv_in   = 1'b1;
               kind_in = bdc_pkg::KIND_DEADLOCK;
               pid_in  = e_ff[PW-1:0];
               safe_in = 1'b0;
               last_in = left_ff == PC'(1);
               left_in = left_ff - PC'(1);
               e_in    = e_ff + PC'(1);
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bdc_pkg::ST_IDLE;
         cnt_ff      <= '0;
         p_ff        <= '0;
         len_ff      <= '0;
         e_ff        <= '0;
         left_ff     <= '0;
         progress_ff <= 1'b0;
         fin_ff      <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         p_ff        <= p_in;
         len_ff      <= len_in;
         e_ff        <= e_in;
         left_ff     <= left_in;
         progress_ff <= progress_in;
         fin_ff      <= fin_in;
         rv_ff       <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ridx_d_ff <= rd_ridx;
      kind_ff   <= kind_in;
      pid_ff    <= pid_in;
      safe_ff   <= safe_in;
      last_ff   <= last_in;
      if (order_we) order_ff[len_ff[PW-1:0]] <= p_ff[PW-1:0];
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {{(8 - PW - 1){1'b0}}, safe_ff, pid_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
